// ----- sv/ssrc_pkg.sv -----
`default_nettype none

package ssrc_pkg;

    localparam logic CMD_FRAME_BYTE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    localparam logic REPLY_VERDICT  = 1'b0;
    localparam logic REPLY_READ     = 1'b1;

    localparam logic [1:0] ST_FILTERED = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_CLOSED   = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_V4      = 2'd1,
        KIND_V6      = 2'd2,
        KIND_BAD     = 2'd3
    } net_kind_t;

    typedef struct packed {
        logic        reply_kind;
        logic        used;
        logic [15:0] port;
        logic        wr;
        logic [1:0]  wr_state;
        logic        rd;
        logic        open_seen;
    } ssrc_op_t;

endpackage

`default_nettype wire

// ----- sv/syn_scan_reply_classifier.sv -----
`default_nettype none

// Classifies replies to a TCP SYN port scan. Captured frames enter one byte per word
// (Ethernet, or a 4-byte null header when loopback mode is set) and read commands may be
// mixed in at any point. One word is taken every cycle while the queue has space; a verdict or read
// answer passes through the queue, the registered read of the single-port status table
// and an output register. After reset the status table is swept to filtered, one entry per
// cycle, and s_tready stays low until the sweep ends; configuration writes are accepted
// during the sweep.
module syn_scan_reply_classifier
    import ssrc_pkg::*;
#(
    parameter int PORT_ENTRIES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,   // loopback_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // frame_byte, query_port
    input  wire logic        s_tlast,       // frame_end
    input  wire logic        s_tuser,       // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,       // frame_used, reply_port, port_state, open_seen
    output logic             m_tuser        // reply_kind
);

    logic     in_accept;
    logic     push;
    ssrc_op_t push_op;
    logic     has_space;
    logic     head_valid;
    ssrc_op_t head_op;
    logic     pop;
    logic     clear_busy;

    assign s_tready  = has_space && !clear_busy;
    assign in_accept = s_tvalid && s_tready;

    ssrc_front #(
        .PORT_ENTRIES(PORT_ENTRIES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_accept  (in_accept),
        .in_command (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_end     (s_tlast),
        .in_query   (s_tdata[23:8]),
        .push       (push),
        .push_op    (push_op)
    );

    ssrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .has_space (has_space),
        .head_valid(head_valid),
        .head_op   (head_op),
        .pop       (pop)
    );

    ssrc_back #(
        .PORT_ENTRIES(PORT_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_op   (head_op),
        .pop       (pop),
        .clear_busy(clear_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_no_accept_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("word accepted before status table sweep");

    a_open_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[19]) |=> (!m_tvalid || m_tdata[19]))
        else $error("open_seen dropped");

    a_used_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
        (m_tuser == REPLY_VERDICT && (m_tdata[18:17] == ST_OPEN || m_tdata[18:17] == ST_CLOSED)))
        else $error("used frame without an updated status");

    a_open_implies_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0] && m_tdata[18:17] == ST_OPEN) |-> m_tdata[19])
        else $error("open port reported without open_seen");

endmodule

`default_nettype wire

// ----- sv/ssrc_front.sv -----
`default_nettype none

module ssrc_front
    import ssrc_pkg::*;
#(
    parameter int PORT_ENTRIES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_accept,
    input  wire logic        in_command,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_end,
    input  wire logic [15:0] in_query,
    output logic             push,
    output ssrc_op_t         push_op
);

    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP     = 8'h06;
    localparam logic [7:0]  FLAGS_SYN_ACK = 8'h12;
    localparam logic [7:0]  FLAGS_RST     = 8'h04;
    localparam logic [6:0]  NULL_HDR_LEN  = 7'd4;
    localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
    localparam logic [6:0]  MIN_ETH_V4    = 7'd54;
    localparam logic [6:0]  MIN_ETH_V6    = 7'd74;
    localparam logic [6:0]  POS_MAX       = 7'd127;
    localparam logic [16:0] PORT_LIMIT    = 17'(PORT_ENTRIES);

    logic        loopback_reg;
    logic [6:0]  pos_reg, pos_next;
    net_kind_t   kind_reg, kind_next;
    logic [6:0]  tstart_reg, tstart_next;
    logic        tcp_reg, tcp_next;
    logic [15:0] sport_reg, sport_next;
    logic [8:0]  flags_reg, flags_next;
    logic        open_seen_reg, open_seen_next;

    logic [6:0]  base;
    logic [15:0] etype;
    logic        seg;
    logic        in_range;
    logic        is_syn_ack;
    logic        is_rst;

    // byte parser
    always_comb begin
        base        = loopback_reg ? NULL_HDR_LEN : ETH_HDR_LEN;
        etype       = sport_reg | {8'h00, in_byte};
        kind_next   = kind_reg;
        tstart_next = tstart_reg;
        tcp_next    = tcp_reg;
        sport_next  = sport_reg;
        flags_next  = flags_reg;

        if (!loopback_reg) begin
            if (pos_reg == 7'd12) begin
                sport_next = {in_byte, 8'h00};
            end else if (pos_reg == 7'd13) begin
                sport_next = 16'h0000;
                if (etype == ETYPE_IPV4) begin
                    kind_next = KIND_V4;
                end else if (etype == ETYPE_IPV6) begin
                    kind_next   = KIND_V6;
                    tstart_next = base + 7'd40;
                end else begin
                    kind_next = KIND_BAD;
                end
            end
        end else if (pos_reg == base) begin
            if (in_byte[7:4] == 4'd4) begin
                kind_next = KIND_V4;
            end else if (in_byte[7:4] == 4'd6) begin
                kind_next   = KIND_V6;
                tstart_next = base + 7'd40;
            end else begin
                kind_next = KIND_BAD;
            end
        end

        if (kind_next == KIND_V4) begin
            if (pos_reg == base) begin
                if (in_byte[3:0] < 4'd5) begin
                    kind_next = KIND_BAD;
                end else begin
                    tstart_next = base + {1'b0, in_byte[3:0], 2'b00};
                end
            end else if (pos_reg == base + 7'd9) begin
                tcp_next = (in_byte == PROTO_TCP);
            end
        end else if (kind_next == KIND_V6 && pos_reg == base + 7'd6) begin
            tcp_next = (in_byte == PROTO_TCP);
        end

        if ((kind_next == KIND_V4 || kind_next == KIND_V6) && tcp_next) begin
            if (pos_reg == tstart_next) begin
                sport_next = {in_byte, 8'h00};
            end else if (pos_reg == tstart_next + 7'd1) begin
                sport_next = sport_next | {8'h00, in_byte};
            end else if (pos_reg == tstart_next + 7'd13) begin
                flags_next = {1'b1, in_byte};
            end
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    // frame verdict and read answers
    always_comb begin
        seg = flags_next[8] && tcp_next && (kind_next == KIND_V4 || kind_next == KIND_V6);
        if (!loopback_reg) begin
            seg = seg && (pos_next >= ((kind_next == KIND_V4) ? MIN_ETH_V4 : MIN_ETH_V6));
        end
        in_range   = ({1'b0, sport_next} < PORT_LIMIT);
        is_syn_ack = (flags_next[7:0] == FLAGS_SYN_ACK);
        is_rst     = ((flags_next[7:0] & FLAGS_RST) != 8'h00);

        open_seen_next = open_seen_reg;
        push_op        = '0;
        push           = 1'b0;
        if (in_accept) begin
            if (in_command == CMD_READ) begin
                push               = 1'b1;
                push_op.reply_kind = REPLY_READ;
                push_op.port       = in_query;
                push_op.rd         = ({1'b0, in_query} < PORT_LIMIT);
                push_op.wr_state   = ST_FILTERED;
                push_op.open_seen  = open_seen_reg;
            end else if (in_end) begin
                push               = 1'b1;
                push_op.reply_kind = REPLY_VERDICT;
                push_op.port       = seg ? sport_next : 16'h0000;
                push_op.wr         = seg && in_range && (is_syn_ack || is_rst);
                push_op.used       = push_op.wr;
                push_op.wr_state   = is_syn_ack ? ST_OPEN : ST_CLOSED;
                push_op.rd         = seg && in_range && !push_op.wr;
                if (seg && in_range && is_syn_ack) begin
                    open_seen_next = 1'b1;
                end
                push_op.open_seen  = open_seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loopback_reg  <= 1'b0;
            pos_reg       <= '0;
            kind_reg      <= KIND_UNKNOWN;
            tstart_reg    <= '0;
            tcp_reg       <= 1'b0;
            sport_reg     <= '0;
            flags_reg     <= '0;
            open_seen_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                loopback_reg <= cfg_wr_data;
            end
            open_seen_reg <= open_seen_next;
            if (in_accept && in_command == CMD_FRAME_BYTE) begin
                if (in_end) begin
                    pos_reg    <= '0;
                    kind_reg   <= KIND_UNKNOWN;
                    tstart_reg <= '0;
                    tcp_reg    <= 1'b0;
                    sport_reg  <= '0;
                    flags_reg  <= '0;
                end else begin
                    pos_reg    <= pos_next;
                    kind_reg   <= kind_next;
                    tstart_reg <= tstart_next;
                    tcp_reg    <= tcp_next;
                    sport_reg  <= sport_next;
                    flags_reg  <= flags_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/ssrc_queue.sv -----
`default_nettype none

module ssrc_queue
    import ssrc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire ssrc_op_t push_op,
    output logic          has_space,
    output logic          head_valid,
    output ssrc_op_t      head_op,
    input  wire logic     pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ssrc_op_t         entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign has_space  = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entries[rd_ptr_reg];
    assign do_push    = push && has_space;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (do_pop) begin
                rd_ptr_reg <= PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/ssrc_back.sv -----
`default_nettype none

module ssrc_back
    import ssrc_pkg::*;
#(
    parameter int PORT_ENTRIES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  wire ssrc_op_t    head_op,
    output logic             pop,
    output logic             clear_busy,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tuser
);

    localparam int ADDR_W = $clog2(PORT_ENTRIES);

    logic [1:0]        mem [PORT_ENTRIES];
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [1:0]        q_reg;
    logic              p1_valid_reg;
    ssrc_op_t          p1_op_reg;
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic              out_used_reg;
    logic [15:0]       out_port_reg;
    logic [1:0]        out_state_reg;
    logic              out_open_reg;

    logic              p1_move;
    logic              issue;
    logic [ADDR_W-1:0] op_addr;
    logic [1:0]        p1_state;

    assign clear_busy = clr_busy_reg;
    assign p1_move    = p1_valid_reg && (!out_valid_reg || m_tready);
    assign issue      = head_valid && !clr_busy_reg && (!p1_valid_reg || p1_move);
    assign pop        = issue;
    assign op_addr    = head_op.port[ADDR_W-1:0];
    assign p1_state   = p1_op_reg.wr ? p1_op_reg.wr_state :
                        p1_op_reg.rd ? q_reg : ST_FILTERED;

    // status table: clearing pass first, then at most one access per queued word
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= ST_FILTERED;
        end else if (issue && head_op.wr) begin
            mem[op_addr] <= head_op.wr_state;
        end
        if (issue && head_op.rd) begin
            q_reg <= mem[op_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_op_reg <= head_op;
        end
        if (p1_move) begin
            out_kind_reg  <= p1_op_reg.reply_kind;
            out_used_reg  <= p1_op_reg.used;
            out_port_reg  <= p1_op_reg.port;
            out_state_reg <= p1_state;
            out_open_reg  <= p1_op_reg.open_seen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(PORT_ENTRIES - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (issue) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_move) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'h0, out_open_reg, out_state_reg, out_port_reg, out_used_reg};

endmodule

`default_nettype wire

// ----- dv/syn_scan_reply_classifier_tb.sv -----
`default_nettype none

module syn_scan_reply_classifier_tb;
    import ssrc_pkg::*;

    localparam int TABLE_ENTRIES = 65536;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS  = 160;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_FRAMES  = 1;

    localparam logic [7:0]  FL_SYN_ACK = 8'h12;
    localparam logic [7:0]  FL_RST     = 8'h04;
    localparam logic [7:0]  FL_SYN     = 8'h02;
    localparam logic [7:0]  FL_ACK     = 8'h10;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [7:0]  PROTO_UDP  = 8'h11;
    localparam int NULL_HDR   = 4;
    localparam int ETH_HDR    = 14;
    localparam int MIN_ETH_V4 = 54;
    localparam int MIN_ETH_V6 = 74;
    localparam int POS_LIMIT  = 127;

    typedef enum logic [1:0] {
        STIM_WORD,
        STIM_CFG,
        STIM_DRAIN
    } stim_op_t;

    typedef struct {
        stim_op_t    op;
        logic        cmd;
        logic [7:0]  data;
        logic        last;
        logic [15:0] port;
        logic        quiet;
    } stim_t;

    typedef struct {
        logic        kind;
        logic        used;
        logic [15:0] port;
        logic [1:0]  state;
        logic        open_seen;
    } reply_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [23:0] s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        s_tuser     = 1'b0;
    logic        m_tready    = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;

    syn_scan_reply_classifier u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // classifier state mirrored by the testbench
    logic        lb_mode;
    logic [6:0]  pos;
    logic [6:0]  tcp_at;
    net_kind_t   nkind;
    logic        is_tcp;
    logic [15:0] sport;
    logic [8:0]  flags;
    logic [1:0]  status_mirror [TABLE_ENTRIES];
    logic        open_flag;

    stim_t       pending_words [$];
    reply_t      expected_replies [$];
    stim_t       cur_word;
    logic [7:0]  frame_buf [$];
    logic [15:0] port_pool [8];
    logic        build_quiet = 1'b0;
    logic        quiet_mode  = 1'b0;
    logic        drain_wait  = 1'b0;
    int          drain_left  = 0;
    int          gap_left    = 0;
    int          rdy_hold    = 0;
    int          word_total  = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    function automatic void clear_frame();
        pos    = '0;
        nkind  = KIND_UNKNOWN;
        tcp_at = '0;
        is_tcp = 1'b0;
        sport  = '0;
        flags  = '0;
    endfunction

    function automatic void set_kind(net_kind_t k, int base);
        nkind = k;
        if (k == KIND_V6) begin
            tcp_at = 7'(base + 40);
        end
    endfunction

    function automatic void take_frame_byte(logic [7:0] b);
        int p;
        int base;
        int t;
        logic [15:0] etype;
        p = int'(pos);
        base = lb_mode ? NULL_HDR : ETH_HDR;
        if (!lb_mode) begin
            if (p == 12) begin
                sport = {b, 8'h00};
            end else if (p == 13) begin
                etype = {sport[15:8], b};
                sport = '0;
                if (etype == ETYPE_IPV4) begin
                    set_kind(KIND_V4, base);
                end else if (etype == ETYPE_IPV6) begin
                    set_kind(KIND_V6, base);
                end else begin
                    set_kind(KIND_BAD, base);
                end
            end
        end else if (p == base) begin
            if (b[7:4] == 4'd4) begin
                set_kind(KIND_V4, base);
            end else if (b[7:4] == 4'd6) begin
                set_kind(KIND_V6, base);
            end else begin
                set_kind(KIND_BAD, base);
            end
        end

        if (nkind == KIND_V4) begin
            if (p == base) begin
                if (b[3:0] < 4'd5) begin
                    nkind = KIND_BAD;
                end else begin
                    tcp_at = 7'(base + int'(b[3:0]) * 4);
                end
            end else if (p == base + 9) begin
                is_tcp = (b == PROTO_TCP);
            end
        end else if (nkind == KIND_V6 && p == base + 6) begin
            is_tcp = (b == PROTO_TCP);
        end

        if ((nkind == KIND_V4 || nkind == KIND_V6) && is_tcp) begin
            t = int'(tcp_at);
            if (p == t) begin
                sport = {b, 8'h00};
            end else if (p == t + 1) begin
                sport = sport | {8'h00, b};
            end else if (p == t + 13) begin
                flags = {1'b1, b};
            end
        end

        if (p < POS_LIMIT) begin
            pos = 7'(p + 1);
        end
    endfunction

    function automatic void classify_word(stim_t w);
        reply_t r;
        logic   seg;
        int     len;
        if (w.cmd == CMD_READ) begin
            r.kind      = REPLY_READ;
            r.used      = 1'b0;
            r.port      = w.port;
            r.state     = status_mirror[w.port];
            r.open_seen = open_flag;
            expected_replies.push_back(r);
        end else begin
            take_frame_byte(w.data);
            if (w.last) begin
                seg = flags[8] && is_tcp && (nkind == KIND_V4 || nkind == KIND_V6);
                len = int'(pos);
                if (seg && !lb_mode) begin
                    seg = len >= ((nkind == KIND_V4) ? MIN_ETH_V4 : MIN_ETH_V6);
                end
                r.used = 1'b0;
                if (seg && int'(sport) < TABLE_ENTRIES) begin
                    if (flags[7:0] == FL_SYN_ACK) begin
                        status_mirror[sport] = ST_OPEN;
                        open_flag = 1'b1;
                        r.used = 1'b1;
                    end else if ((flags[7:0] & FL_RST) != 8'h00) begin
                        status_mirror[sport] = ST_CLOSED;
                        r.used = 1'b1;
                    end
                end
                r.kind      = REPLY_VERDICT;
                r.port      = seg ? sport : 16'h0000;
                r.state     = seg ? status_mirror[sport] : ST_FILTERED;
                r.open_seen = open_flag;
                expected_replies.push_back(r);
                clear_frame();
            end
        end
    endfunction

    // stimulus construction

    function automatic void push_item(stim_op_t op, logic cmd, logic [7:0] data, logic last,
                                      logic [15:0] port);
        stim_t w;
        w.op    = op;
        w.cmd   = cmd;
        w.data  = data;
        w.last  = last;
        w.port  = port;
        w.quiet = build_quiet;
        pending_words.push_back(w);
        if (op == STIM_WORD) begin
            word_total++;
        end
    endfunction

    function automatic void push_read(logic [15:0] port);
        push_item(STIM_WORD, CMD_READ, 8'($urandom), 1'($urandom), port);
    endfunction

    function automatic void push_cfg(logic mode);
        push_item(STIM_DRAIN, CMD_FRAME_BYTE, 8'h00, 1'b0, 16'h0000);
        push_item(STIM_CFG, CMD_FRAME_BYTE, {7'h00, mode}, 1'b0, 16'h0000);
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0: pick_port = 16'h0000;
            1: pick_port = 16'hFFFF;
            2, 3: pick_port = 16'($urandom);
            default: pick_port = port_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [7:0] pick_flags();
        case ($urandom_range(0, 7))
            0, 1, 2: pick_flags = FL_SYN_ACK;
            3, 4: pick_flags = FL_RST | (8'($urandom) & ~FL_RST);
            5: pick_flags = FL_RST | FL_ACK;
            6: pick_flags = 8'($urandom);
            default: pick_flags = $urandom_range(0, 1) ? FL_SYN : FL_ACK;
        endcase
    endfunction

    function automatic void set_at(int idx, logic [7:0] v);
        if (idx < frame_buf.size()) begin
            frame_buf[idx] = v;
        end
    endfunction

    function automatic void build_frame(logic lb, logic v6, int ihl, logic bad_kind, logic tcp,
                                        logic [15:0] src, logic [7:0] fl, int len);
        int base;
        int t;
        int ver;
        logic [15:0] etype;
        frame_buf.delete();
        for (int i = 0; i < len; i++) begin
            frame_buf.push_back(8'($urandom));
        end
        base = lb ? NULL_HDR : ETH_HDR;
        t = base + (v6 ? 40 : ihl * 4);
        if (lb) begin
            for (int i = 0; i < NULL_HDR; i++) begin
                set_at(i, 8'h00);
            end
        end else begin
            etype = bad_kind ? ETYPE_ARP : (v6 ? ETYPE_IPV6 : ETYPE_IPV4);
            set_at(12, etype[15:8]);
            set_at(13, etype[7:0]);
        end
        if (lb && bad_kind) begin
            // any version nibble other than 4 and 6
            ver = $urandom_range(0, 13);
            if (ver >= 4) ver++;
            if (ver >= 6) ver++;
            set_at(base, {4'(ver), 4'(ihl)});
        end else begin
            set_at(base, v6 ? {4'd6, 4'($urandom)} : {4'd4, 4'(ihl)});
        end
        if (v6) begin
            set_at(base + 6, tcp ? PROTO_TCP : PROTO_UDP);
        end else begin
            set_at(base + 9, tcp ? PROTO_TCP : PROTO_UDP);
        end
        if (v6 || ihl >= 5) begin
            set_at(t, src[15:8]);
            set_at(t + 1, src[7:0]);
            set_at(t + 13, fl);
        end
    endfunction

    // frame bytes go out with read commands mixed in
    function automatic void send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            if ($urandom_range(0, 24) == 0) begin
                push_read(pick_port());
            end
            push_item(STIM_WORD, CMD_FRAME_BYTE, frame_buf[i], i == frame_buf.size() - 1,
                      16'($urandom));
        end
    endfunction

    function automatic void random_frame(logic lb);
        logic v6;
        logic bad_kind;
        logic tcp;
        int   ihl;
        int   len;
        int   t;
        int   r;
        v6 = $urandom_range(0, 2) == 0;
        r = $urandom_range(0, 15);
        ihl = (r == 0) ? $urandom_range(0, 4) : (r < 4) ? $urandom_range(6, 15) : 5;
        bad_kind = $urandom_range(0, 11) == 0;
        tcp = $urandom_range(0, 9) != 0;
        t = (lb ? NULL_HDR : ETH_HDR) + (v6 ? 40 : (ihl < 5 ? 20 : ihl * 4));
        r = $urandom_range(0, 9);
        if (r == 0) begin
            len = $urandom_range(1, t + 13);
        end else if (r == 1) begin
            len = $urandom_range(120, 140);
        end else begin
            len = t + 14 + $urandom_range(0, 12);
        end
        build_frame(lb, v6, ihl, bad_kind, tcp, pick_port(), pick_flags(), len);
        send_frame();
    endfunction

    function automatic void noise_frame();
        frame_buf.delete();
        repeat ($urandom_range(1, 30)) begin
            frame_buf.push_back(8'($urandom));
        end
        send_frame();
    endfunction

    // driver
    always @(posedge aclk) begin : driver
        stim_t it;
        logic  take;
        logic  nxt_valid;
        logic  nxt_cfg;
        nxt_cfg = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                classify_word(cur_word);
            end
            take = !(s_tvalid && !s_tready);
            if (take) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_wait) begin
                    if (expected_replies.size() == 0) begin
                        if (drain_left > 0) drain_left--;
                        else drain_wait = 1'b0;
                    end
                end else if (pending_words.size() > 0) begin
                    if (pending_words[0].op == STIM_WORD && !pending_words[0].quiet &&
                        $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(0, 2);
                    end else begin
                        it = pending_words.pop_front();
                        quiet_mode = it.quiet;
                        case (it.op)
                            STIM_WORD: begin
                                nxt_valid = 1'b1;
                                cur_word = it;
                                s_tdata <= {it.port, it.data};
                                s_tlast <= it.last;
                                s_tuser <= it.cmd;
                            end
                            STIM_CFG: begin
                                nxt_cfg = 1'b1;
                                cfg_wr_data <= it.data[0];
                                lb_mode = it.data[0];
                            end
                            default: begin
                                drain_wait = 1'b1;
                                drain_left = SETTLE_CYCLES;
                            end
                        endcase
                    end
                end
                s_tvalid <= nxt_valid;
            end
        end
        cfg_wr_en <= nxt_cfg;
    end

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin : monitor
        reply_t exp_r;
        logic   ready_nxt;
        ready_nxt = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected reply word: tuser %0h tdata %0h", m_tuser, m_tdata);
                    mismatch_count++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    check_field("reply_kind", 16'(exp_r.kind), 16'(m_tuser));
                    check_field("frame_used", 16'(exp_r.used), 16'(m_tdata[0]));
                    check_field("reply_port", exp_r.port, m_tdata[16:1]);
                    check_field("port_state", 16'(exp_r.state), 16'(m_tdata[18:17]));
                    check_field("open_seen", 16'(exp_r.open_seen), 16'(m_tdata[19]));
                end
            end
            if (rdy_hold > 0) begin
                rdy_hold--;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                rdy_hold = $urandom_range(0, 2);
            end else begin
                ready_nxt = 1'b1;
            end
        end
        m_tready <= ready_nxt;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int start;
        int frames;
        logic mode;
        foreach (status_mirror[i]) status_mirror[i] = ST_FILTERED;
        open_flag = 1'b0;
        lb_mode = 1'b0;
        clear_frame();
        foreach (port_pool[i]) port_pool[i] = 16'($urandom);

        // directed, ethernet framing
        push_cfg(1'b0);
        push_read(16'h0000);
        push_read(16'hFFFF);
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b1, 16'hFFFF, FL_SYN_ACK, 60);
        send_frame();
        build_frame(1'b0, 1'b1, 5, 1'b0, 1'b1, 16'h0000, FL_RST, 80);
        send_frame();
        push_read(16'hFFFF);
        push_read(16'h0000);
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b1, port_pool[0], FL_ACK, 60);
        send_frame();
        // short frames that reach the flags byte, then other odd frames
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b1, port_pool[1], FL_SYN_ACK, 50);
        send_frame();
        build_frame(1'b0, 1'b1, 5, 1'b0, 1'b1, port_pool[1], FL_RST, 70);
        send_frame();
        build_frame(1'b0, 1'b0, 4, 1'b0, 1'b1, port_pool[2], FL_SYN_ACK, 60);
        send_frame();
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b1, port_pool[2], FL_SYN_ACK, 135);
        send_frame();
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b1, port_pool[3], FL_SYN_ACK, 1);
        send_frame();
        build_frame(1'b0, 1'b0, 5, 1'b1, 1'b1, port_pool[3], FL_RST, 60);
        send_frame();
        build_frame(1'b0, 1'b0, 5, 1'b0, 1'b0, port_pool[3], FL_RST, 60);
        send_frame();

        // directed, loopback framing
        push_cfg(1'b1);
        build_frame(1'b1, 1'b0, 15, 1'b0, 1'b1, port_pool[4], FL_RST, 84);
        send_frame();
        build_frame(1'b1, 1'b1, 5, 1'b0, 1'b1, port_pool[5], FL_SYN_ACK, 64);
        send_frame();
        build_frame(1'b1, 1'b0, 5, 1'b1, 1'b1, port_pool[5], FL_RST, 44);
        send_frame();
        build_frame(1'b1, 1'b0, 5, 1'b0, 1'b1, port_pool[6], FL_SYN_ACK, 34);
        send_frame();
        push_read(port_pool[4]);
        push_read(port_pool[5]);

        // random phases, alternating framing; the last runs without idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = ph[0];
            build_quiet = (ph == RANDOM_PHASES - 1);
            push_cfg(mode);
            start = word_total;
            frames = 0;
            while (word_total - start < RANDOM_WORDS / RANDOM_PHASES || frames < PHASE_FRAMES) begin
                case ($urandom_range(0, 11))
                    0: noise_frame();
                    1: push_read(pick_port());
                    2: begin
                        if (!build_quiet) begin
                            push_item(STIM_DRAIN, CMD_FRAME_BYTE, 8'h00, 1'b0, 16'h0000);
                        end
                    end
                    default: begin
                        random_frame(mode);
                        frames++;
                    end
                endcase
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || drain_wait || gap_left != 0 ||
               expected_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);

        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/ssrc_pkg.sv
sv/ssrc_front.sv
sv/ssrc_queue.sv
sv/ssrc_back.sv
sv/syn_scan_reply_classifier.sv
dv/syn_scan_reply_classifier_tb.sv
